### rtl/ppbank_pkg.sv
// Shared types, constants and action codes for the ping-pong register bank.
package ppbank_pkg;

  localparam int unsigned SINGLE_COUNT = 8;
  localparam int unsigned DOUBLE_COUNT = 8;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned IDX_EXT_W = 8;

  localparam int unsigned SHARED_AW = (SINGLE_COUNT > 1) ? $clog2(SINGLE_COUNT) : 1;
  localparam int unsigned BANK_AW   = (DOUBLE_COUNT > 1) ? $clog2(DOUBLE_COUNT) : 1;

  localparam logic [IDX_EXT_W-1:0] SHARED_LIMIT = IDX_EXT_W'(SINGLE_COUNT);
  localparam logic [IDX_EXT_W-1:0] TOTAL_LIMIT  = IDX_EXT_W'(SINGLE_COUNT + DOUBLE_COUNT);

  localparam bit BOOT_ONE = (DOUBLE_COUNT != 0) && (SINGLE_COUNT >= 3);

  localparam logic [ACTION_W-1:0] ACT_CPU_WRITE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CPU_READ   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ENG_WRITE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ENG_READ   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CPU_ARM    = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_ENG_RELEASE = 3'd5;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    index;
    logic [DATA_W-1:0]   write_data;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              index_error;
    logic              config_bank;
    logic              source_bank;
    logic              source_enabled;
    logic              config_ready;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

endpackage

### rtl/ping_pong_register_bank_unit.sv
// Top level of the ping-pong register bank: controller plus datapath.
// A word is taken when start is high and busy is low; its result is on response
// with done high for one cycle, after the controller has gone through ST_EXEC,
// where the result is registered, to ST_RESP. No new word is taken until the
// result has been shown: busy stays high from acceptance through the result cycle.
// The receiver cannot stall the result. Synchronous reset clears the register
// file (shared entry one to one), pointers and enables, and sets ready.
module ping_pong_register_bank_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ppbank_pkg::cmd_t  command,
  output logic              busy,
  output logic              done,
  output ppbank_pkg::rsp_t  response
);

  ppbank_pkg::ctrl_t ctrl;

  ppbank_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  ppbank_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .command  (command),
    .response (response)
  );

endmodule

### rtl/ppbank_ctrl.sv
// Controller state machine that sequences one command word at a time.
module ppbank_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output ppbank_pkg::ctrl_t  ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy         = (state != ST_IDLE);
  assign done         = (state == ST_RESP);
  assign ctrl.capture = (state == ST_IDLE) && start;
  assign ctrl.execute = (state == ST_EXEC);

`ifndef SYNTH
  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ctrl.execute)
    else $error("accepted word did not move to execution");

  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.execute |=> done)
    else $error("execution was not followed by a result strobe");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && !ctrl.capture))
    else $error("new word taken while a result was shown");
`endif

endmodule

### rtl/ppbank_datapath.sv
// Register file, bank pointers, enable flags and result register.
module ppbank_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ppbank_pkg::ctrl_t  ctrl,
  input  ppbank_pkg::cmd_t   command,
  output ppbank_pkg::rsp_t   response
);

  ppbank_pkg::cmd_t cmd_q;

  logic [ppbank_pkg::DATA_W-1:0] shared_regs [ppbank_pkg::SINGLE_COUNT];
  logic [ppbank_pkg::DATA_W-1:0] bank_zero_regs [ppbank_pkg::DOUBLE_COUNT];
  logic [ppbank_pkg::DATA_W-1:0] bank_one_regs [ppbank_pkg::DOUBLE_COUNT];

  logic cfg_pointer;
  logic src_pointer;
  logic enable_zero;
  logic enable_one;
  logic ready_flag;

  logic cfg_pointer_next;
  logic src_pointer_next;
  logic enable_zero_next;
  logic enable_one_next;
  logic ready_flag_next;

  logic [ppbank_pkg::IDX_EXT_W-1:0] idx_ext;
  logic [ppbank_pkg::IDX_EXT_W-1:0] bank_off_ext;
  logic [ppbank_pkg::SHARED_AW-1:0] shared_sel;
  logic [ppbank_pkg::BANK_AW-1:0]   bank_sel;
  logic                             is_access;
  logic                             is_write;
  logic                             cpu_side;
  logic                             bank;
  logic                             in_shared;
  logic                             in_bank;
  logic                             wr_shared;
  logic                             wr_bank_zero;
  logic                             wr_bank_one;
  logic [ppbank_pkg::DATA_W-1:0]    read_value;
  ppbank_pkg::rsp_t                 rsp_next;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command;
    end
  end

  assign idx_ext      = ppbank_pkg::IDX_EXT_W'(cmd_q.index);
  assign bank_off_ext = idx_ext - ppbank_pkg::SHARED_LIMIT;
  assign shared_sel   = idx_ext[ppbank_pkg::SHARED_AW-1:0];
  assign bank_sel     = bank_off_ext[ppbank_pkg::BANK_AW-1:0];

  assign is_access = (cmd_q.action == ppbank_pkg::ACT_CPU_WRITE) ||
                     (cmd_q.action == ppbank_pkg::ACT_CPU_READ)  ||
                     (cmd_q.action == ppbank_pkg::ACT_ENG_WRITE) ||
                     (cmd_q.action == ppbank_pkg::ACT_ENG_READ);
  assign is_write  = (cmd_q.action == ppbank_pkg::ACT_CPU_WRITE) ||
                     (cmd_q.action == ppbank_pkg::ACT_ENG_WRITE);
  assign cpu_side  = (cmd_q.action == ppbank_pkg::ACT_CPU_WRITE) ||
                     (cmd_q.action == ppbank_pkg::ACT_CPU_READ);
  assign bank      = cpu_side ? cfg_pointer : src_pointer;
  assign in_shared = (idx_ext < ppbank_pkg::SHARED_LIMIT);
  assign in_bank   = !in_shared && (idx_ext < ppbank_pkg::TOTAL_LIMIT);

  assign wr_shared    = ctrl.execute && is_write && in_shared;
  assign wr_bank_zero = ctrl.execute && is_write && in_bank && !bank;
  assign wr_bank_one  = ctrl.execute && is_write && in_bank && bank;

  always_comb begin
    read_value = '0;
    if (is_access && !is_write) begin
      if (in_shared) begin
        read_value = shared_regs[shared_sel];
      end else if (in_bank) begin
        read_value = bank ? bank_one_regs[bank_sel] : bank_zero_regs[bank_sel];
      end
    end
  end

  always_comb begin
    cfg_pointer_next = cfg_pointer;
    src_pointer_next = src_pointer;
    enable_zero_next = enable_zero;
    enable_one_next  = enable_one;
    ready_flag_next  = ready_flag;
    case (cmd_q.action)
      ppbank_pkg::ACT_CPU_ARM: begin
        if (!cfg_pointer) begin
          enable_zero_next = 1'b1;
        end else begin
          enable_one_next = 1'b1;
        end
        if (enable_zero_next && enable_one_next) begin
          ready_flag_next = 1'b0;
        end
        cfg_pointer_next = !cfg_pointer;
      end
      ppbank_pkg::ACT_ENG_RELEASE: begin
        if (!src_pointer) begin
          enable_zero_next = 1'b0;
        end else begin
          enable_one_next = 1'b0;
        end
        ready_flag_next  = 1'b1;
        src_pointer_next = !src_pointer;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_next.read_data      = read_value;
    rsp_next.index_error    = is_access && !in_shared && !in_bank;
    rsp_next.config_bank    = cfg_pointer_next;
    rsp_next.source_bank    = src_pointer_next;
    rsp_next.source_enabled = src_pointer_next ? enable_one_next : enable_zero_next;
    rsp_next.config_ready   = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pointer <= 1'b0;
      src_pointer <= 1'b0;
      enable_zero <= 1'b0;
      enable_one  <= 1'b0;
      ready_flag  <= 1'b1;
    end else if (ctrl.execute) begin
      cfg_pointer <= cfg_pointer_next;
      src_pointer <= src_pointer_next;
      enable_zero <= enable_zero_next;
      enable_one  <= enable_one_next;
      ready_flag  <= ready_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppbank_pkg::SINGLE_COUNT; i++) begin
        shared_regs[i] <= ppbank_pkg::DATA_W'((i == 1) && ppbank_pkg::BOOT_ONE);
      end
      for (int i = 0; i < ppbank_pkg::DOUBLE_COUNT; i++) begin
        bank_zero_regs[i] <= '0;
        bank_one_regs[i]  <= '0;
      end
    end else begin
      if (wr_shared) begin
        shared_regs[shared_sel] <= cmd_q.write_data;
      end
      if (wr_bank_zero) begin
        bank_zero_regs[bank_sel] <= cmd_q.write_data;
      end
      if (wr_bank_one) begin
        bank_one_regs[bank_sel] <= cmd_q.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      response <= rsp_next;
    end
  end

`ifndef SYNTH
  a_not_ready_both_armed: assert property (@(posedge clk) disable iff (rst)
    !ready_flag |-> (enable_zero && enable_one))
    else $error("ready dropped while a bank is still free");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(ctrl.execute) |-> ($stable(cfg_pointer) && $stable(src_pointer) &&
                             $stable(ready_flag)))
    else $error("bank control changed outside execution");

  a_write_one_target: assert property (@(posedge clk) disable iff (rst)
    $countones({wr_shared, wr_bank_zero, wr_bank_one}) <= 1)
    else $error("a write word hit more than one register");
`endif

endmodule
